[rtl/bprd_pkg.sv]
`default_nettype none
package bprd_pkg;

   // largest occupied count that a record may carry
   localparam int MAX_PIECES = 32;

   // output queue, sized so two results can always be pushed after a check
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_PIECE    = 2'd0;
   localparam logic [1:0] KIND_SUMMARY  = 2'd1;
   localparam logic [1:0] KIND_TRUNC    = 2'd2;
   localparam logic [1:0] KIND_TOO_MANY = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_marker;
   } req_type;

   typedef struct packed {
      logic [1:0]        item_kind;
      logic [5:0]        square_index;
      logic [2:0]        piece_kind;
      logic              piece_color;
      logic [4:0]        piece_number;
      logic              side_to_move;
      logic [6:0]        fifty_move_count;
      logic [6:0]        piece_total;
      logic signed [15:0] eval_score;
      logic [7:0]        game_result;
      logic              last;
   } rsp_type;

   // results produced by one decode step, first slot always used first
   typedef struct packed {
      logic push0;
      logic push1;
   } push_type;

   typedef struct packed {
      logic                   room;
      logic [QUEUE_LVL_W-1:0] level;
   } queue_status_type;

endpackage
`default_nettype wire

[rtl/bprd_queue.sv]
`default_nettype none
module bprd_queue
   import bprd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire push_type         push,
   input  wire rsp_type          push_data0,
   input  wire rsp_type          push_data1,
   output queue_status_type      status,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rsp_type               rsp_data
);

   rsp_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] head_ff, head_in;
   logic [QUEUE_PTR_W-1:0] tail_ff, tail_in;
   logic [QUEUE_LVL_W-1:0] level_ff, level_in;
   logic                   pop;
   logic [QUEUE_PTR_W-1:0] tail_next;

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = entry_ff[head_ff];
   assign pop       = rsp_valid && !rsp_stall;
   assign tail_next = tail_ff + QUEUE_PTR_W'(1);

   // room for two pushes regardless of a pop this cycle
   assign status.room  = (level_ff <= QUEUE_LVL_W'(QUEUE_DEPTH - 2));
   assign status.level = level_ff;

   always_comb begin
      head_in  = pop ? head_ff + QUEUE_PTR_W'(1) : head_ff;
      tail_in  = tail_ff + QUEUE_PTR_W'(push.push0) + QUEUE_PTR_W'(push.push1);
      level_in = level_ff + QUEUE_LVL_W'(push.push0) + QUEUE_LVL_W'(push.push1)
                 - QUEUE_LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         level_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
      end
      if (push.push0) begin
         entry_ff[tail_ff] <= push_data0;
      end
      if (push.push1) begin
         entry_ff[tail_next] <= push_data1;
      end
   end

endmodule
`default_nettype wire

[rtl/bprd_decode.sv]
`default_nettype none
module bprd_decode
   import bprd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   output push_type     push,
   output rsp_type      rsp0,
   output rsp_type      rsp1
);

   typedef enum logic [2:0] {
      PH_OCC,
      PH_TURN,
      PH_PIECES,
      PH_SCORE,
      PH_RESULT
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] occ_ff, occ_in;
   logic        turn_ff, turn_in;
   logic [6:0]  clock50_ff, clock50_in;
   logic [6:0]  count_ff, count_in;
   logic [6:0]  done_ff, done_in;
   logic [15:0] score_ff, score_in;
   logic [7:0]  outcome_ff, outcome_in;
   logic        halted_ff, halted_in;

   logic [7:0]  b;
   logic [63:0] occ_base, occ_lane, occ1, occ2;
   logic [6:0]  count_acc;
   logic [5:0]  sq0, sq1;
   logic [6:0]  done1, done2;
   logic        has_second;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   // isolate lowest set bit, then encode the one-hot word
   function automatic logic [5:0] lowest_bit(input logic [63:0] v);
      logic [63:0] one;
      logic [5:0]  idx;
      one = v & (~v + 64'd1);
      idx = '0;
      for (int i = 0; i < 64; i++) begin
         idx = idx | ({6{one[i]}} & 6'(i));
      end
      return idx;
   endfunction

   assign b          = item.data_byte;
   assign occ_base   = (bif_ff == 3'd0) ? 64'd0 : occ_ff;
   assign occ_lane   = occ_base | ({56'd0, b} << {bif_ff, 3'b000});
   assign count_acc  = ((bif_ff == 3'd0) ? 7'd0 : count_ff) + {3'd0, popcount8(b)};
   assign occ1       = occ_ff & (occ_ff - 64'd1);
   assign occ2       = occ1 & (occ1 - 64'd1);
   assign sq0        = lowest_bit(occ_ff);
   assign sq1        = lowest_bit(occ1);
   assign done1      = done_ff + 7'd1;
   assign done2      = done_ff + 7'd2;
   assign has_second = (done1 < count_ff);

   always_comb begin
      phase_in   = phase_ff;
      bif_in     = bif_ff;
      occ_in     = occ_ff;
      turn_in    = turn_ff;
      clock50_in = clock50_ff;
      count_in   = count_ff;
      done_in    = done_ff;
      score_in   = score_ff;
      outcome_in = outcome_ff;
      halted_in  = halted_ff;
      push       = '0;
      rsp0       = '0;
      rsp1       = '0;

      if (step && !halted_ff) begin
         if (item.end_marker) begin
            // end marker between records is silent
            if (!(phase_ff == PH_OCC && bif_ff == 3'd0)) begin
               push.push0     = 1'b1;
               rsp0.item_kind = KIND_TRUNC;
               rsp0.last      = 1'b1;
               halted_in      = 1'b1;
            end
         end else begin
            unique case (phase_ff)
               PH_OCC: begin
                  occ_in   = occ_lane;
                  count_in = count_acc;
                  bif_in   = bif_ff + 3'd1;
                  if (bif_ff == 3'd7) begin
                     bif_in  = 3'd0;
                     done_in = 7'd0;
                     if (count_acc > 7'(MAX_PIECES)) begin
                        push.push0       = 1'b1;
                        rsp0.item_kind   = KIND_TOO_MANY;
                        rsp0.piece_total = count_acc;
                        rsp0.last        = 1'b1;
                        halted_in        = 1'b1;
                     end else begin
                        phase_in = PH_TURN;
                     end
                  end
               end
               PH_TURN: begin
                  turn_in    = b[0];
                  clock50_in = b[7:1];
                  phase_in   = (count_ff == 7'd0) ? PH_SCORE : PH_PIECES;
                  bif_in     = 3'd0;
               end
               PH_PIECES: begin
                  push.push0        = 1'b1;
                  rsp0.item_kind    = KIND_PIECE;
                  rsp0.square_index = sq0;
                  rsp0.piece_kind   = b[3:1];
                  rsp0.piece_color  = b[0];
                  rsp0.piece_number = done_ff[4:0];
                  rsp0.last         = !has_second;
                  occ_in            = occ1;
                  done_in           = done1;
                  if (has_second) begin
                     push.push1        = 1'b1;
                     rsp1.item_kind    = KIND_PIECE;
                     rsp1.square_index = sq1;
                     rsp1.piece_kind   = b[7:5];
                     rsp1.piece_color  = b[4];
                     rsp1.piece_number = done1[4:0];
                     rsp1.last         = 1'b1;
                     occ_in            = occ2;
                     done_in           = done2;
                  end
                  if ((has_second ? done2 : done1) >= count_ff) begin
                     phase_in = PH_SCORE;
                     bif_in   = 3'd0;
                  end
               end
               PH_SCORE: begin
                  if (bif_ff == 3'd0) begin
                     score_in = {8'd0, b};
                  end else if (bif_ff == 3'd1) begin
                     score_in = {b, score_ff[7:0]};
                  end
                  bif_in = bif_ff + 3'd1;
                  if (bif_ff == 3'd3) begin
                     bif_in   = 3'd0;
                     phase_in = PH_RESULT;
                  end
               end
               PH_RESULT: begin
                  if (bif_ff == 3'd0) begin
                     outcome_in = b;
                  end
                  bif_in = bif_ff + 3'd1;
                  if (bif_ff == 3'd3) begin
                     push.push0            = 1'b1;
                     rsp0.item_kind        = KIND_SUMMARY;
                     rsp0.side_to_move     = turn_ff;
                     rsp0.fifty_move_count = clock50_ff;
                     rsp0.piece_total      = count_ff;
                     rsp0.eval_score       = score_ff;
                     rsp0.game_result      = (bif_ff == 3'd0) ? b : outcome_ff;
                     rsp0.last             = 1'b1;
                     bif_in                = 3'd0;
                     phase_in              = PH_OCC;
                  end
               end
               default: begin
                  phase_in = PH_OCC;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_OCC;
         bif_ff     <= '0;
         occ_ff     <= '0;
         turn_ff    <= 1'b0;
         clock50_ff <= '0;
         count_ff   <= '0;
         done_ff    <= '0;
         score_ff   <= '0;
         outcome_ff <= '0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         bif_ff     <= bif_in;
         occ_ff     <= occ_in;
         turn_ff    <= turn_in;
         clock50_ff <= clock50_in;
         count_ff   <= count_in;
         done_ff    <= done_in;
         score_ff   <= score_in;
         outcome_ff <= outcome_in;
         halted_ff  <= halted_in;
      end
   end

endmodule
`default_nettype wire

[rtl/bitboard_position_record_decoder.sv]
// flow: an accepted item waits in the input register until the output queue has room
// for two results; it is then decoded and its results are queued and offered on rsp_
// throughput: one byte per cycle while the output queue has room; a piece byte gives up to
// two results and the single-read output queue then sets the pace at one result per cycle
// reset: synchronous, clears decoder state, input valid flag and output queue
`default_nettype none
module bitboard_position_record_decoder
   import bprd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic             in_valid_ff, in_valid_in;
   req_type          in_data_ff;
   logic             accept;
   logic             step;
   push_type         push;
   rsp_type          rsp0, rsp1;
   queue_status_type status;

   assign step      = in_valid_ff && status.room;
   assign req_stall = in_valid_ff && !status.room;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_data_ff <= req_data;
      end
   end

   bprd_decode u_decode (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_data_ff),
      .push  (push),
      .rsp0  (rsp0),
      .rsp1  (rsp1)
   );

   bprd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data0 (rsp0),
      .push_data1 (rsp1),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      status.level <= QUEUE_LVL_W'(QUEUE_DEPTH))
      else $error("output queue overflow");

   a_push_order: assert property (@(posedge clock) disable iff (reset)
      push.push1 |-> push.push0)
      else $error("second result pushed without first");

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_data_ff))
      else $error("waiting input item lost or changed");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.item_kind == KIND_TRUNC ||
                    rsp_data.item_kind == KIND_TOO_MANY) |-> rsp_data.last)
      else $error("error item not marked last");
`endif

endmodule
`default_nettype wire
